// File: src/dsc_pkg.sv
// dsc_pkg: shared types and constants for the der signature checker
// holds the status and kind codes, the front-to-back record and the result record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   // default limit on stream length (counter saturates here)
   localparam int unsigned DSC_MAX_SIG_BYTES = 72;
   localparam int unsigned DSC_MIN_SIG_BYTES = 9;
   localparam int unsigned DSC_QUEUE_DEPTH   = 2;

   localparam logic [7:0] TAG_SEQ  = 8'h30;
   localparam logic [7:0] TAG_INT  = 8'h02;

   typedef enum logic [1:0] {
      KIND_STRUCT = 2'd0,
      KIND_R      = 2'd1,
      KIND_S      = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_SHORT   = 4'd1,
      ST_LONG    = 4'd2,
      ST_SEQ_TAG = 4'd3,
      ST_SEQ_LEN = 4'd4,
      ST_R_TAG   = 4'd5,
      ST_R_ZERO  = 4'd6,
      ST_R_LONG  = 4'd7,
      ST_S_TAG   = 4'd8,
      ST_S_ZERO  = 4'd9,
      ST_S_LEN   = 4'd10,
      ST_R_NEG   = 4'd11,
      ST_R_PAD   = 4'd12,
      ST_S_NEG   = 4'd13,
      ST_S_PAD   = 4'd14
   } status_type;

   // failure flag bit for a byte test is its status code minus one
   localparam int unsigned FLAG_BITS   = 14;
   localparam int unsigned FL_SEQ_TAG  = 2;
   localparam int unsigned FL_R_TAG    = 4;
   localparam int unsigned FL_S_TAG    = 7;
   localparam int unsigned FL_R_NEG    = 10;
   localparam int unsigned FL_R_PAD    = 11;
   localparam int unsigned FL_S_NEG    = 12;
   localparam int unsigned FL_S_PAD    = 13;

   // classified byte plus the state snapshot the verdict needs
   typedef struct packed {
      logic [7:0]           data;
      kind_type             kind;
      logic [6:0]           value_index;
      logic                 last;
      logic [7:0]           len;
      logic                 overflow;
      logic [FLAG_BITS-1:0] flags;
      logic [7:0]           declared_total;
      logic [7:0]           r_length;
      logic [7:0]           s_length;
   } record_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic [6:0] value_index;
      logic       done;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

// File: src/dsc_front.sv
// dsc_front: accepts signature bytes, tracks position and header fields, classifies each byte
// pushes one record per byte into the queue
// depends on dsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsc_front #(
   parameter int unsigned MAX_SIG_BYTES = dsc_pkg::DSC_MAX_SIG_BYTES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_in_last,
   input  wire logic               queue_full,
   output logic                    push,
   output dsc_pkg::record_type     push_rec
);
   import dsc_pkg::*;

   logic [6:0]           pos_ff, pos_in;
   logic [7:0]           decl_ff, decl_in;
   logic [7:0]           rlen_ff, rlen_in;
   logic [7:0]           slen_ff, slen_in;
   logic [7:0]           fvb_ff, fvb_in;
   logic [FLAG_BITS-1:0] flags_ff, flags_in;

   logic [7:0]           decl_nx, rlen_nx, slen_nx, fvb_nx;
   logic [FLAG_BITS-1:0] flags_nx;
   logic                 overflow;
   logic [8:0]           p9, r4, r5, s_start;
   logic [9:0]           s_end;
   kind_type             kind;
   logic [6:0]           idx;

   assign push     = req_valid && !queue_full;
   assign overflow = pos_ff >= 7'(MAX_SIG_BYTES);
   assign p9       = {2'b00, pos_ff};
   assign r4       = {1'b0, rlen_ff} + 9'd4;
   assign r5       = {1'b0, rlen_ff} + 9'd5;
   assign s_start  = {1'b0, rlen_ff} + 9'd6;
   assign s_end    = {1'b0, s_start} + {2'b00, slen_ff};

   // byte tests and header capture
   always_comb begin
      decl_nx  = decl_ff;
      rlen_nx  = rlen_ff;
      slen_nx  = slen_ff;
      fvb_nx   = fvb_ff;
      flags_nx = flags_ff;
      kind     = KIND_STRUCT;
      idx      = '0;
      if (!overflow) begin
         case (pos_ff)
            7'd0: begin
               if (req_in_byte != TAG_SEQ) flags_nx[FL_SEQ_TAG] = 1'b1;
            end
            7'd1: begin
               decl_nx = req_in_byte;
            end
            7'd2: begin
               if (req_in_byte != TAG_INT) flags_nx[FL_R_TAG] = 1'b1;
            end
            7'd3: begin
               rlen_nx = req_in_byte;
            end
            default: begin
               if (p9 < r4) begin
                  kind = KIND_R;
                  idx  = pos_ff - 7'd4;
               end else if (p9 >= s_start && {1'b0, p9} < s_end) begin
                  kind = KIND_S;
                  idx  = 7'(p9 - s_start);
               end
               if (pos_ff == 7'd4) begin
                  if (req_in_byte[7]) flags_nx[FL_R_NEG] = 1'b1;
                  fvb_nx = req_in_byte;
               end
               if (pos_ff == 7'd5 && rlen_ff > 8'd1 && fvb_ff == 8'd0 && !req_in_byte[7])
                  flags_nx[FL_R_PAD] = 1'b1;
               if (p9 == r4 && req_in_byte != TAG_INT) flags_nx[FL_S_TAG] = 1'b1;
               if (p9 == r5) slen_nx = req_in_byte;
               if (p9 == s_start) begin
                  if (req_in_byte[7]) flags_nx[FL_S_NEG] = 1'b1;
                  fvb_nx = req_in_byte;
               end
               if (p9 == s_start + 9'd1 && slen_ff > 8'd1 && fvb_ff == 8'd0 &&
                   !req_in_byte[7])
                  flags_nx[FL_S_PAD] = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      push_rec.data           = req_in_byte;
      push_rec.kind           = kind;
      push_rec.value_index    = idx;
      push_rec.last           = req_in_last;
      push_rec.len            = {1'b0, pos_ff} + 8'd1;
      push_rec.overflow       = overflow;
      push_rec.flags          = flags_nx;
      push_rec.declared_total = decl_nx;
      push_rec.r_length       = rlen_nx;
      push_rec.s_length       = slen_nx;
   end

   // state returns to reset after the final byte
   always_comb begin
      pos_in   = pos_ff;
      decl_in  = decl_ff;
      rlen_in  = rlen_ff;
      slen_in  = slen_ff;
      fvb_in   = fvb_ff;
      flags_in = flags_ff;
      if (push) begin
         if (req_in_last) begin
            pos_in   = '0;
            decl_in  = '0;
            rlen_in  = '0;
            slen_in  = '0;
            fvb_in   = '0;
            flags_in = '0;
         end else begin
            pos_in   = overflow ? pos_ff : pos_ff + 7'd1;
            decl_in  = decl_nx;
            rlen_in  = rlen_nx;
            slen_in  = slen_nx;
            fvb_in   = fvb_nx;
            flags_in = flags_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         decl_ff  <= '0;
         rlen_ff  <= '0;
         slen_ff  <= '0;
         fvb_ff   <= '0;
         flags_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         decl_ff  <= decl_in;
         rlen_ff  <= rlen_in;
         slen_ff  <= slen_in;
         fvb_ff   <= fvb_in;
         flags_ff <= flags_in;
      end
   end

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 7'(MAX_SIG_BYTES))
      else $error("position counter above limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      push && req_in_last |=> pos_ff == 7'd0 && flags_ff == '0)
      else $error("state not cleared after final byte");

endmodule

`default_nettype wire

// File: src/dsc_queue.sv
// dsc_queue: short flip-flop queue between classifier and verdict stage
// depends on dsc_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module dsc_queue #(
   parameter int unsigned DEPTH = dsc_pkg::DSC_QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dsc_pkg::record_type push_rec,
   input  wire logic                pop,
   output logic                     head_valid,
   output dsc_pkg::record_type      head_rec,
   output logic                     full
);
   import dsc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   record_type      entry_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign full       = count_ff == CW'(DEPTH);
   assign head_rec   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop)      count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_rec;
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: src/dsc_back.sv
// dsc_back: verdict stage and result register
// takes queue records, picks the first failing check on the final byte
// depends on dsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsc_back #(
   parameter int unsigned MAX_SIG_BYTES = dsc_pkg::DSC_MAX_SIG_BYTES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire dsc_pkg::record_type head_rec,
   output logic                     pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output dsc_pkg::result_type      rsp_res
);
   import dsc_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;
   status_type verdict;

   always_comb begin
      if (head_rec.len < 8'(DSC_MIN_SIG_BYTES))
         verdict = ST_SHORT;
      else if (head_rec.overflow || head_rec.len >= 8'(MAX_SIG_BYTES))
         verdict = ST_LONG;
      else if (head_rec.flags[FL_SEQ_TAG])
         verdict = ST_SEQ_TAG;
      else if (head_rec.declared_total != head_rec.len - 8'd2)
         verdict = ST_SEQ_LEN;
      else if (head_rec.flags[FL_R_TAG])
         verdict = ST_R_TAG;
      else if (head_rec.r_length == 8'd0)
         verdict = ST_R_ZERO;
      else if ({1'b0, head_rec.r_length} + 9'd5 >= {1'b0, head_rec.len})
         verdict = ST_R_LONG;
      else if (head_rec.flags[FL_S_TAG])
         verdict = ST_S_TAG;
      else if (head_rec.s_length == 8'd0)
         verdict = ST_S_ZERO;
      else if ({2'b00, head_rec.r_length} + {2'b00, head_rec.s_length} + 10'd6 !=
               {2'b00, head_rec.len})
         verdict = ST_S_LEN;
      else if (head_rec.flags[FL_R_NEG])
         verdict = ST_R_NEG;
      else if (head_rec.flags[FL_R_PAD])
         verdict = ST_R_PAD;
      else if (head_rec.flags[FL_S_NEG])
         verdict = ST_S_NEG;
      else if (head_rec.flags[FL_S_PAD])
         verdict = ST_S_PAD;
      else
         verdict = ST_OK;
   end

   assign pop       = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in  = pop || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff.data        <= head_rec.data;
         res_ff.kind        <= head_rec.kind;
         res_ff.value_index <= head_rec.value_index;
         res_ff.done        <= head_rec.last;
         res_ff.status      <= head_rec.last ? verdict : ST_OK;
      end
   end

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !res_ff.done |-> res_ff.status == ST_OK)
      else $error("status on non-final result");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(res_ff))
      else $error("result lost under stall");

endmodule

`default_nettype wire

// File: src/der_signature_checker_top.sv
// der_signature_checker_top: strict der ecdsa signature checker, byte stream in, classified bytes out
// instantiates dsc_front, dsc_queue, dsc_back; depends on dsc_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+--------------------
//  req     | in        | req_in_byte[7:0] req_in_last                  | req_valid / req_stall
//  rsp     | out       | rsp_out_byte rsp_out_kind rsp_value_index     | rsp_valid / rsp_stall
//          |           | rsp_done_res rsp_status                       |
//
//  one byte per cycle sustained while rsp_stall is low; an accepted byte is written
//  into the queue and reaches the result register when the queue pops it
//  the classifier does all byte tests in the accept cycle; the verdict is
//  computed when the record leaves the queue
//  reset is synchronous, active high, and clears counters, flags and valids
//  req_stall rises only when the two-entry queue is full; under back-to-back
//  input that happens after the output side stalls

module der_signature_checker_top #(
   parameter int unsigned MAX_SIG_BYTES = dsc_pkg::DSC_MAX_SIG_BYTES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input byte stream
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   // classified results
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_out_kind,
   output logic [6:0]      rsp_value_index,
   output logic            rsp_done_res,
   output logic [3:0]      rsp_status
);
   import dsc_pkg::*;

   logic       push;
   logic       pop;
   logic       queue_full;
   logic       head_valid;
   record_type push_rec;
   record_type head_rec;
   result_type res;

   // stall is driven only by queue occupancy, never by req_valid
   assign req_stall = queue_full;

   // front: position tracking, header capture, byte classification
   dsc_front #(
      .MAX_SIG_BYTES(MAX_SIG_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (queue_full),
      .push        (push),
      .push_rec    (push_rec)
   );

   // decoupling queue so either side can stall alone
   dsc_queue #(
      .DEPTH(DSC_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .full       (queue_full)
   );

   // back: verdict priority chain and output register
   dsc_back #(
      .MAX_SIG_BYTES(MAX_SIG_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_res    (res)
   );

   assign rsp_out_byte    = res.data;
   assign rsp_out_kind    = res.kind;
   assign rsp_value_index = res.value_index;
   assign rsp_done_res    = res.done;
   assign rsp_status      = res.status;

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_STRUCT |-> !rsp_done_res || rsp_status != ST_OK ||
      rsp_out_kind == KIND_S)
      else $error("ok verdict on a byte that is not the end of s");

endmodule

`default_nettype wire
